// ===== src/weather_ascii_line_parser_defines.svh =====
// assertion macros for the weather line parser
`ifndef WEATHER_ASCII_LINE_PARSER_DEFINES_SVH
`define WEATHER_ASCII_LINE_PARSER_DEFINES_SVH

// same-cycle implication, checked on i_clk outside reset
`define WALP_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk outside reset
`define WALP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/walp_pkg.sv =====
// types, character codes and helper functions of the weather line parser
package walp_pkg;

    localparam int NUM_FIELDS = 6;
    localparam int VAL_W      = 32;
    localparam int ACC_W      = 31;
    localparam int SUM_W      = 36;
    localparam int WGT_W      = 20;
    localparam int FLD_W      = 3;
    localparam int POS_W      = 3;
    localparam int PREFIX_LEN = 4;

    localparam logic [ACC_W-1:0] SAT_LIMIT = 31'd2000000000;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_R     = 8'h52;

    // value slots
    localparam logic [FLD_W-1:0] FLD_SPEED = 3'd0;
    localparam logic [FLD_W-1:0] FLD_DIR   = 3'd1;
    localparam logic [FLD_W-1:0] FLD_PRESS = 3'd2;
    localparam logic [FLD_W-1:0] FLD_TEMP  = 3'd3;
    localparam logic [FLD_W-1:0] FLD_HUM   = 3'd4;
    localparam logic [FLD_W-1:0] FLD_RAIN  = 3'd5;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_PREFIX = 2'd1,
        ST_NO_NUMBER  = 2'd2
    } t_status;

    typedef enum logic [6:0] {
        PH_PREFIX = 7'b0000001,
        PH_TOKEN  = 7'b0000010,
        PH_KEY    = 7'b0000100,
        PH_BLANK  = 7'b0001000,
        PH_NUM    = 7'b0010000,
        PH_SKIP   = 7'b0100000,
        PH_DEAD   = 7'b1000000
    } t_phase;

    typedef logic signed [VAL_W-1:0] t_value;

    // powers of ten up to the finest supported scale
    function automatic logic [WGT_W-1:0] pow10_lut(input logic [2:0] n);
        logic [WGT_W-1:0] p;
        unique case (n)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            default: p = 20'd1000000;
        endcase
        return p;
    endfunction

    // expected character of the line prefix "0R0,"
    function automatic logic [7:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = CH_ZERO;
            3'd1:    ch = CH_R;
            3'd2:    ch = CH_ZERO;
            default: ch = CH_COMMA;
        endcase
        return ch;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // key letter lookup: hit bit over slot index
    function automatic logic [FLD_W:0] key_lookup(input logic [7:0] c);
        logic [FLD_W:0] r;
        unique case (c)
            CH_S:    r = {1'b1, FLD_SPEED};
            CH_D:    r = {1'b1, FLD_DIR};
            CH_P:    r = {1'b1, FLD_PRESS};
            CH_T:    r = {1'b1, FLD_TEMP};
            CH_H:    r = {1'b1, FLD_HUM};
            CH_R:    r = {1'b1, FLD_RAIN};
            default: r = {1'b0, FLD_SPEED};
        endcase
        return r;
    endfunction

endpackage

// ===== src/walp_in_if.sv =====
// character channel of the weather line parser
interface walp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ===== src/walp_out_if.sv =====
// result channel of the weather line parser
interface walp_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] wind_speed;
    logic signed [31:0] wind_direction;
    logic signed [31:0] pressure;
    logic signed [31:0] temperature;
    logic signed [31:0] humidity;
    logic signed [31:0] rainfall;

    modport source (output valid, output status, output wind_speed, output wind_direction,
                    output pressure, output temperature, output humidity, output rainfall,
                    input ready);
    modport sink   (input valid, input status, input wind_speed, input wind_direction,
                    input pressure, input temperature, input humidity, input rainfall,
                    output ready);
endinterface

// ===== src/weather_ascii_line_parser.sv =====
// weather station reply line parser, top level
//
// i_in carries one character per beat plus a flag on the final character of
// a line. The line must open with "0R0,"; keyed tokens S=, D=, P=, T=, H= and
// R= load a signed fixed-point value (units of 10^-FRAC_DIGITS, saturating
// at +/-2e9) into one of six stored slots.
// o_out gives one beat per line, taken from the final character: the line
// status (ok, bad prefix, token without a number) and all six slots.
// A beat is registered on entry and parsed straight from the input register
// into the output register, one character per cycle except while a final
// character waits for a stalled o_out.
// While o_out is stalled the parser keeps consuming characters that give no
// result; a final character waits in the input register until the output
// register frees, and i_in.ready drops behind it.
// Reset (synchronous, active low) returns the parser to the prefix check,
// clears the six slots and empties both registers.
module weather_ascii_line_parser #(
    parameter int FRAC_DIGITS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    walp_in_if.sink     i_in,
    walp_out_if.source  o_out
);
    import walp_pkg::*;

    `include "weather_ascii_line_parser_defines.svh"

    localparam int FC_W = $clog2(FRAC_DIGITS + 1);
    localparam logic [WGT_W-1:0] SCALE = pow10_lut(3'(FRAC_DIGITS));

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // parser state
    t_phase           r_phase,  n_phase;
    logic [POS_W-1:0] r_pos,    n_pos;
    logic [FLD_W-1:0] r_fld,    n_fld;
    logic [ACC_W-1:0] r_acc,    n_acc;
    logic             r_neg,    n_neg;
    logic [FC_W-1:0]  r_fc,     n_fc;
    logic             r_dseen,  n_dseen;
    logic             r_pseen,  n_pseen;
    t_status          r_status, n_status;
    t_status          n_res_status;
    t_value           r_vals [NUM_FIELDS];
    t_value           n_vals [NUM_FIELDS];

    // output register
    logic    r_out_valid;
    t_status r_out_status;
    t_value  r_out_vals [NUM_FIELDS];

    logic out_free;
    logic adv;

    // digit accumulation
    logic [3:0]       dig;
    logic [WGT_W-1:0] tk_weight;
    logic [23:0]      tk_prod;
    logic [SUM_W-1:0] tk_ext;
    logic [SUM_W-1:0] tk_sum;
    logic [ACC_W-1:0] tk_acc;
    logic [FC_W-1:0]  tk_fc;
    logic [FLD_W:0]   key_hit;

    // handshake
    assign out_free   = !r_out_valid || o_out.ready;
    assign adv        = r_in_valid && (!r_in_last || out_free);
    assign i_in.ready = !r_in_valid || adv;

    // low nibble of an ascii digit is its value
    assign dig     = r_in_char[3:0];
    assign key_hit = key_lookup(r_in_char);
    assign tk_ext  = SUM_W'(r_acc);
    assign tk_prod = 24'(dig) * 24'(tk_weight);

    // weight of the next digit and the fraction count after it
    always_comb begin
        tk_fc = r_fc;
        if (!r_pseen) begin
            tk_weight = SCALE;
        end else if (r_fc < FC_W'(FRAC_DIGITS)) begin
            tk_weight = pow10_lut(3'(FRAC_DIGITS - 1) - 3'(r_fc));
            tk_fc     = r_fc + 1'b1;
        end else begin
            tk_weight = '0;
        end
    end

    // scaled sum with saturation
    always_comb begin
        if (!r_pseen) begin
            tk_sum = (tk_ext << 3) + (tk_ext << 1) + SUM_W'(tk_prod);
        end else begin
            tk_sum = tk_ext + SUM_W'(tk_prod);
        end
        tk_acc = (tk_sum > SUM_W'(SAT_LIMIT)) ? SAT_LIMIT : ACC_W'(tk_sum);
    end

    // per-character phase update, end of line finish and line reset
    always_comb begin
        logic fin;
        fin      = 1'b0;
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_fld    = r_fld;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_fc     = r_fc;
        n_dseen  = r_dseen;
        n_pseen  = r_pseen;
        n_status = r_status;
        n_vals   = r_vals;

        unique case (r_phase)
            PH_PREFIX: begin
                if (r_pos < POS_W'(PREFIX_LEN) && r_in_char == prefix_char(r_pos)) begin
                    n_pos = r_pos + 1'b1;
                    if (n_pos == POS_W'(PREFIX_LEN)) begin
                        n_phase = PH_TOKEN;
                    end
                end else begin
                    n_status = ST_BAD_PREFIX;
                    n_phase  = PH_DEAD;
                end
            end
            PH_TOKEN: begin
                if (r_in_char == CH_COMMA) begin
                    n_phase = PH_TOKEN;
                end else if (key_hit[FLD_W]) begin
                    n_fld   = key_hit[FLD_W-1:0];
                    n_phase = PH_KEY;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_KEY: begin
                if (r_in_char == CH_EQ) begin
                    n_acc   = '0;
                    n_neg   = 1'b0;
                    n_fc    = '0;
                    n_dseen = 1'b0;
                    n_pseen = 1'b0;
                    n_phase = PH_BLANK;
                end else if (r_in_char == CH_COMMA) begin
                    n_phase = PH_TOKEN;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_BLANK: begin
                if (is_blank(r_in_char)) begin
                    n_phase = PH_BLANK;
                end else if (r_in_char == CH_PLUS || r_in_char == CH_MINUS) begin
                    n_neg   = (r_in_char == CH_MINUS);
                    n_phase = PH_NUM;
                end else if (is_digit(r_in_char)) begin
                    n_acc   = tk_acc;
                    n_fc    = tk_fc;
                    n_dseen = 1'b1;
                    n_phase = PH_NUM;
                end else if (r_in_char == CH_POINT) begin
                    n_pseen = 1'b1;
                    n_phase = PH_NUM;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_NUM: begin
                if (is_digit(r_in_char)) begin
                    n_acc   = tk_acc;
                    n_fc    = tk_fc;
                    n_dseen = 1'b1;
                end else if (r_in_char == CH_POINT && !r_pseen) begin
                    n_pseen = 1'b1;
                end else begin
                    fin = 1'b1;
                end
            end
            PH_SKIP: begin
                if (r_in_char == CH_COMMA) begin
                    n_phase = PH_TOKEN;
                end
            end
            PH_DEAD: begin
                n_phase = PH_DEAD;
            end
            default: begin
                n_phase = PH_DEAD;
            end
        endcase

        // number ended by another character
        if (fin) begin
            if (!r_dseen) begin
                n_vals[r_fld] = '0;
                n_status      = ST_NO_NUMBER;
                n_phase       = PH_DEAD;
            end else begin
                n_vals[r_fld] = r_neg ? -$signed({1'b0, r_acc}) : $signed({1'b0, r_acc});
                n_phase       = (r_in_char == CH_COMMA) ? PH_TOKEN : PH_SKIP;
            end
        end

        // end of line: short prefix fails, open number is finished
        if (r_in_last) begin
            if (n_phase == PH_PREFIX) begin
                n_status = ST_BAD_PREFIX;
            end else if (n_phase == PH_BLANK || n_phase == PH_NUM) begin
                if (!n_dseen) begin
                    n_vals[n_fld] = '0;
                    n_status      = ST_NO_NUMBER;
                end else begin
                    n_vals[n_fld] = n_neg ? -$signed({1'b0, n_acc}) : $signed({1'b0, n_acc});
                end
            end
        end
        n_res_status = n_status;

        if (r_in_last) begin
            n_phase  = PH_PREFIX;
            n_pos    = '0;
            n_fld    = '0;
            n_acc    = '0;
            n_neg    = 1'b0;
            n_fc     = '0;
            n_dseen  = 1'b0;
            n_pseen  = 1'b0;
            n_status = ST_OK;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_char <= i_in.char_code;
            r_in_last <= i_in.last_char;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_PREFIX;
            r_pos    <= '0;
            r_fld    <= '0;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_fc     <= '0;
            r_dseen  <= 1'b0;
            r_pseen  <= 1'b0;
            r_status <= ST_OK;
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_vals[i] <= '0;
            end
        end else if (adv) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_fld    <= n_fld;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_fc     <= n_fc;
            r_dseen  <= n_dseen;
            r_pseen  <= n_pseen;
            r_status <= n_status;
            r_vals   <= n_vals;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && r_in_last) begin
            r_out_status <= n_res_status;
            r_out_vals   <= n_vals;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out_status;
    assign o_out.wind_speed     = r_out_vals[FLD_SPEED];
    assign o_out.wind_direction = r_out_vals[FLD_DIR];
    assign o_out.pressure       = r_out_vals[FLD_PRESS];
    assign o_out.temperature    = r_out_vals[FLD_TEMP];
    assign o_out.humidity       = r_out_vals[FLD_HUM];
    assign o_out.rainfall       = r_out_vals[FLD_RAIN];

    // checks
    `WALP_ASSERT_NXT(a_last_gives_result, adv && r_in_last, r_out_valid, "final beat lost")
    `WALP_ASSERT_NXT(a_line_restart, adv && r_in_last,
                     r_phase == PH_PREFIX && r_status == ST_OK && r_pos == '0,
                     "line state not restarted")
    `WALP_ASSERT(a_acc_saturated, r_in_valid || !r_in_valid, r_acc <= SAT_LIMIT,
                 "accumulator above limit")
    `WALP_ASSERT(a_fail_is_dead, r_status != ST_OK, r_phase == PH_DEAD, "failed line still parsing")
    `WALP_ASSERT_NXT(a_hold_pending, r_in_valid && !adv, r_in_valid && $stable(r_in_char),
                     "pending beat dropped")

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the weather line parser: random reply lines, scoreboard on o_out
module tb_top;
    import walp_pkg::*;

    localparam int FRAC_DIGITS  = 3;
    localparam longint unsigned UNIT_SCALE  = 1000;
    localparam longint unsigned MAG_CEILING = 2000000000;
    localparam int STIM_BEATS   = 1030;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [0:3][7:0] LINE_HEAD   = {CH_ZERO, CH_R, CH_ZERO, CH_COMMA};
    localparam logic [0:5][7:0] KEY_CHARS   = {CH_S, CH_D, CH_P, CH_T, CH_H, CH_R};
    localparam logic [0:5][7:0] BLANK_CHARS = {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    // point, letter e, blank, minus: text after a number; the point stops it only after a point
    localparam logic [0:3][7:0] TAIL_CHARS  = {CH_POINT, 8'h65, CH_SPACE, CH_MINUS};
    localparam logic [7:0]      CH_X        = 8'h78;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       drain;
    } t_char_beat;

    typedef struct packed {
        t_status                          status;
        logic [NUM_FIELDS-1:0][VAL_W-1:0] slot;
    } t_line_report;

    typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    walp_in_if  in_if ();
    walp_out_if out_if ();

    weather_ascii_line_parser #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_char_beat   char_beats [$];
    t_line_report reports_due [$];

    string slot_label [NUM_FIELDS] = '{"wind_speed", "wind_direction", "pressure",
                                       "temperature", "humidity", "rainfall"};

    int errors;
    int chars_sent;
    int lines_checked;
    int lines_by_status [3];
    int burst_left;
    int gap_left;
    int cycle_count;
    int idle_cycles;
    t_rx_mode rx_mode;

    // line parser mirror
    t_phase          ln_phase;
    int              ln_pos;
    int              ln_field;
    int              ln_frac;
    longint unsigned ln_mag;
    bit              ln_neg;
    bit              ln_digit;
    bit              ln_point;
    t_status         ln_status;
    t_value          ln_slot [NUM_FIELDS];

    always #5 i_clk = ~i_clk;

    task automatic flag_error(input string what);
        errors++;
        $display("[%0t] tb_top: %s", $time, what);
    endtask

    function automatic void clear_number();
        ln_mag   = 0;
        ln_neg   = 1'b0;
        ln_frac  = 0;
        ln_digit = 1'b0;
        ln_point = 1'b0;
    endfunction

    function automatic void restart_line();
        ln_phase  = PH_PREFIX;
        ln_pos    = 0;
        ln_field  = 0;
        ln_status = ST_OK;
        clear_number();
    endfunction

    // integer digits scale the magnitude, fraction digits past the resolution drop
    function automatic void add_digit(input logic [7:0] c);
        longint unsigned d;
        d = c - CH_ZERO;
        ln_digit = 1'b1;
        if (!ln_point) begin
            ln_mag = ln_mag * 10 + d * UNIT_SCALE;
        end else if (ln_frac < FRAC_DIGITS) begin
            ln_mag = ln_mag + d * (10 ** (FRAC_DIGITS - 1 - ln_frac));
            ln_frac++;
        end
        if (ln_mag > MAG_CEILING) ln_mag = MAG_CEILING;
    endfunction

    // store the number; a number with no digit zeroes the slot and kills the line
    function automatic bit close_number();
        if (!ln_digit) begin
            ln_slot[ln_field] = '0;
            ln_status = ST_NO_NUMBER;
            ln_phase  = PH_DEAD;
            return 1'b0;
        end
        ln_slot[ln_field] = ln_neg ? -t_value'(ln_mag) : t_value'(ln_mag);
        return 1'b1;
    endfunction

    function automatic void close_at(input logic [7:0] c);
        if (close_number()) begin
            if (c == CH_COMMA) ln_phase = PH_TOKEN;
            else ln_phase = PH_SKIP;
        end
    endfunction

    // advance the mirror by one accepted character, queue the report on the last one
    task automatic parse_char(input logic [7:0] c, input logic last);
        t_line_report rep;
        case (ln_phase)
            PH_PREFIX: begin
                if (ln_pos < PREFIX_LEN && c == LINE_HEAD[ln_pos]) begin
                    ln_pos++;
                    if (ln_pos == PREFIX_LEN) ln_phase = PH_TOKEN;
                end else begin
                    ln_status = ST_BAD_PREFIX;
                    ln_phase  = PH_DEAD;
                end
            end
            PH_TOKEN: begin
                if (c == CH_COMMA) begin
                    ln_phase = PH_TOKEN;
                end else begin
                    ln_phase = PH_SKIP;
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        if (c == KEY_CHARS[k]) begin
                            ln_field = k;
                            ln_phase = PH_KEY;
                        end
                    end
                end
            end
            PH_KEY: begin
                if (c == CH_EQ) begin
                    clear_number();
                    ln_phase = PH_BLANK;
                end else if (c == CH_COMMA) begin
                    ln_phase = PH_TOKEN;
                end else begin
                    ln_phase = PH_SKIP;
                end
            end
            PH_BLANK: begin
                if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
                    // leading blanks are dropped
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    ln_neg   = (c == CH_MINUS);
                    ln_phase = PH_NUM;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    add_digit(c);
                    ln_phase = PH_NUM;
                end else if (c == CH_POINT) begin
                    ln_point = 1'b1;
                    ln_phase = PH_NUM;
                end else begin
                    close_at(c);
                end
            end
            PH_NUM: begin
                if (c >= CH_ZERO && c <= CH_NINE) add_digit(c);
                else if (c == CH_POINT && !ln_point) ln_point = 1'b1;
                else close_at(c);
            end
            PH_SKIP: begin
                if (c == CH_COMMA) ln_phase = PH_TOKEN;
            end
            default: begin
            end
        endcase

        if (last) begin
            if (ln_phase == PH_PREFIX) ln_status = ST_BAD_PREFIX;
            else if (ln_phase == PH_BLANK || ln_phase == PH_NUM) void'(close_number());
            rep.status = ln_status;
            for (int k = 0; k < NUM_FIELDS; k++) rep.slot[k] = ln_slot[k];
            reports_due.push_back(rep);
            restart_line();
        end
    endtask

    task automatic queue_line(input logic [7:0] txt [$], input bit drain);
        t_char_beat beat;
        for (int k = 0; k < txt.size(); k++) begin
            beat.code  = txt[k];
            beat.last  = (k == txt.size() - 1);
            beat.drain = drain && (k == 0);
            char_beats.push_back(beat);
        end
    endtask

    task automatic add_digits(ref logic [7:0] txt [$], input int count);
        for (int k = 0; k < count; k++) txt.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // sender: bursts of beats with random gaps, optional hold until all reports are in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left  = 0;
            gap_left    = 0;
            for (int k = 0; k < NUM_FIELDS; k++) ln_slot[k] = '0;
            restart_line();
        end else begin
            if (in_if.valid && in_if.ready) begin
                parse_char(in_if.char_code, in_if.last_char);
                void'(char_beats.pop_front());
                chars_sent++;
            end
            if (in_if.valid && !in_if.ready) begin
                // beat still offered
            end else if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (char_beats.size() == 0 ||
                         (char_beats[0].drain && reports_due.size() != 0)) begin
                in_if.valid <= 1'b0;
            end else begin
                in_if.valid     <= 1'b1;
                in_if.char_code <= char_beats[0].code;
                in_if.last_char <= char_beats[0].last;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 32);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: gap_left = 0;
                        4, 5, 6, 7: gap_left = $urandom_range(1, 4);
                        default:    gap_left = $urandom_range(5, 20);
                    endcase
                end
            end
        end
    end

    // receiver: stall pattern picked at random from four modes, result beats checked in order
    always @(posedge i_clk) begin : result_check
        t_line_report want;
        t_value       got_slot [NUM_FIELDS];
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            cycle_count  = 0;
            rx_mode      = RX_STEADY;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (reports_due.size() == 0) begin
                    flag_error("result beat with no line pending");
                end else begin
                    want = reports_due.pop_front();
                    lines_checked++;
                    lines_by_status[want.status]++;
                    if (out_if.status !== want.status)
                        flag_error($sformatf("line %0d status got %0d want %0d", lines_checked,
                                             out_if.status, want.status));
                    got_slot = '{out_if.wind_speed, out_if.wind_direction, out_if.pressure,
                                 out_if.temperature, out_if.humidity, out_if.rainfall};
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        if (got_slot[k] !== want.slot[k])
                            flag_error($sformatf("line %0d %s got %0d want %0d", lines_checked,
                                                 slot_label[k], got_slot[k],
                                                 $signed(want.slot[k])));
                    end
                end
            end
            cycle_count++;
            if (cycle_count % 200 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_STEADY: out_if.ready <= 1'b1;
                RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_if.ready <= (cycle_count % 6 == 0);
                default:   out_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top: no progress for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [7:0] txt [$];
        string      head_line;
        int         line_no;
        int         n_tok;
        int         n_int;
        int         n_frac;
        logic [7:0] ch;

        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.char_code  = '0;
        in_if.last_char  = 1'b0;
        out_if.ready     = 1'b0;
        errors           = 0;
        chars_sent       = 0;
        lines_checked    = 0;
        idle_cycles      = 0;
        lines_by_status  = '{0, 0, 0};

        // saturation, blank and sign, leading point with truncation, then a key with no digits
        head_line = "0R0,P=9999999,T=\t-.1234,D=x";
        txt.delete();
        for (int k = 0; k < head_line.len(); k++) txt.push_back(head_line[k]);
        queue_line(txt, 1'b0);
        // one-character lines: zero byte and all-ones byte
        txt = '{8'h00};
        queue_line(txt, 1'b0);
        txt = '{8'hff};
        queue_line(txt, 1'b0);

        line_no = 0;
        while (char_beats.size() < STIM_BEATS) begin
            txt.delete();
            case ($urandom_range(0, 9))
                8: begin
                    // damaged or short prefix, followed by up to four printable characters
                    txt = '{CH_ZERO, CH_R, CH_ZERO, CH_COMMA};
                    if ($urandom_range(0, 1)) txt = txt[0:$urandom_range(0, 2)];
                    txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
                    repeat ($urandom_range(0, 4)) txt.push_back(8'($urandom_range(8'h21, 8'h7e)));
                end
                9: begin
                    // raw noise over the whole byte range
                    repeat ($urandom_range(1, 8)) txt.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    // well-formed line with random tokens
                    txt = '{CH_ZERO, CH_R, CH_ZERO, CH_COMMA};
                    n_tok = $urandom_range(0, 6);
                    for (int t = 0; t < n_tok; t++) begin
                        if (t > 0) txt.push_back(CH_COMMA);
                        case ($urandom_range(0, 19)) inside
                            [0:13]: begin
                                // keyed number
                                txt.push_back(KEY_CHARS[$urandom_range(0, NUM_FIELDS - 1)]);
                                txt.push_back(CH_EQ);
                                if ($urandom_range(0, 3) == 0)
                                    repeat ($urandom_range(1, 2))
                                        txt.push_back(BLANK_CHARS[$urandom_range(0, 5)]);
                                case ($urandom_range(0, 3))
                                    0:       txt.push_back(CH_PLUS);
                                    1:       txt.push_back(CH_MINUS);
                                    default: begin
                                    end
                                endcase
                                n_int  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                                     : $urandom_range(0, 4);
                                n_frac = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 5);
                                if (n_int == 0 && n_frac <= 0 && $urandom_range(0, 1)) n_int = 1;
                                add_digits(txt, n_int);
                                if (n_frac >= 0) begin
                                    txt.push_back(CH_POINT);
                                    add_digits(txt, n_frac);
                                end
                                if ($urandom_range(0, 7) == 0)
                                    txt.push_back(TAIL_CHARS[$urandom_range(0, 3)]);
                            end
                            [14:16]: begin
                                // unknown token, any byte but the comma
                                repeat ($urandom_range(0, 5)) begin
                                    ch = $urandom_range(0, 1) ? 8'($urandom_range(8'h21, 8'h7e))
                                                              : 8'($urandom_range(0, 255));
                                    if (ch == CH_COMMA) ch = CH_POINT;
                                    txt.push_back(ch);
                                end
                            end
                            17: begin
                                // key letter, optionally followed by one random printable character
                                txt.push_back(KEY_CHARS[$urandom_range(0, NUM_FIELDS - 1)]);
                                if ($urandom_range(0, 1))
                                    txt.push_back(8'($urandom_range(8'h21, 8'h7e)));
                            end
                            18: begin
                                // key with no digits at all
                                txt.push_back(KEY_CHARS[$urandom_range(0, NUM_FIELDS - 1)]);
                                txt.push_back(CH_EQ);
                                if ($urandom_range(0, 1)) txt.push_back(CH_MINUS);
                                if ($urandom_range(0, 1)) txt.push_back(CH_POINT);
                                if ($urandom_range(0, 1)) txt.push_back(CH_X);
                            end
                            default: begin
                                // empty token
                            end
                        endcase
                    end
                end
            endcase
            queue_line(txt, line_no % 50 == 0);
            line_no++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_beats.size() != 0) @(posedge i_clk);
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (reports_due.size() != 0) flag_error("reports still pending at end of run");
        $display("tb_top: %0d characters in %0d checked lines", chars_sent, lines_checked);
        $display("tb_top: line status ok %0d, bad prefix %0d, missing number %0d, errors %0d",
                 lines_by_status[ST_OK], lines_by_status[ST_BAD_PREFIX],
                 lines_by_status[ST_NO_NUMBER], errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/walp_pkg.sv
src/walp_in_if.sv
src/walp_out_if.sv
src/weather_ascii_line_parser.sv
verif/tb_top.sv
